/* rtl/core/ttcr_pkg.sv */
package ttcr_pkg;

   // Field widths of the knob converter and the oscillator increment.
   localparam int ADC_BITS = 10;
   localparam int NCO_BITS = 20;

   // Widths of the configuration registers and of the internal values.
   localparam int CFG_W       = 20;
   localparam int DELAY_W     = 16;
   localparam int HYST_W      = 10;
   localparam int ACTION_W    = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int LFO_W       = 8;
   localparam int LFO_MAG_W   = 7;
   localparam int DEBOUNCE_W  = 8;

   // The chorus product is |lfo| times depth, and the sum carries a sign.
   localparam int PROD_W = ADC_BITS + LFO_MAG_W;
   localparam int SUM_W  = ((PROD_W > CFG_W) ? PROD_W : CFG_W) + 2;
   localparam int KNOB_W = ((ADC_BITS > HYST_W) ? ADC_BITS : HYST_W) + 1;

   // Event codes carried in the action field.
   localparam logic [ACTION_W-1:0] ACT_TICK        = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_BUTTON      = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_DELAY_KNOB  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_CHORUS_KNOB = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_LFO_TICK    = 3'd4;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_RATE_NUMERATOR  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INCREMENT_MIN   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INCREMENT_MAX   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAP_LIMIT       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_KNOB_OFFSET     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_KNOB_HYSTERESIS = 3'd5;

   // Debounce pattern: upper nibble forced high, a press edge reads 0xF3.
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_MASK = 8'hF0;
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_EDGE = 8'hF3;

   // Triangle LFO turning points in hundredths, and the scale of the depth.
   localparam logic signed [LFO_W-1:0] LFO_PEAK   = 8'sd100;
   localparam logic signed [LFO_W-1:0] LFO_TROUGH = -8'sd100;
   localparam logic [LFO_MAG_W-1:0]    LFO_SCALE  = 7'd100;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                button_level;
      logic [ADC_BITS-1:0] adc_value;
   } ttcr_req_type;

   typedef struct packed {
      logic [NCO_BITS-1:0] phase_step;
      logic [DELAY_W-1:0]  delay_value;
      logic                in_tap_mode;
      logic                edge_seen;
   } ttcr_rsp_type;

   typedef struct packed {
      logic [CFG_W-1:0]   rate_numerator;
      logic [CFG_W-1:0]   increment_min;
      logic [CFG_W-1:0]   increment_max;
      logic [DELAY_W-1:0] tap_limit;
      logic [DELAY_W-1:0] knob_offset;
      logic [HYST_W-1:0]  knob_hysteresis;
   } ttcr_cfg_type;

   // State of the event logic as seen by the increment datapath.
   typedef struct packed {
      logic [DELAY_W-1:0]   delay_value;
      logic                 tap_active;
      logic                 edge_seen;
      logic                 lfo_negative;
      logic [LFO_MAG_W-1:0] lfo_magnitude;
      logic [ADC_BITS-1:0]  chorus_depth;
   } ttcr_status_type;

   localparam ttcr_cfg_type CFG_RESET = '{
      rate_numerator:  20'd520223,
      increment_min:   20'd450,
      increment_max:   20'd18000,
      tap_limit:       16'd5000,
      knob_offset:     16'd542,
      knob_hysteresis: 10'd5
   };

endpackage

/* rtl/core/ttcr_div.sv */
module ttcr_div #(
   parameter int NUM_W = 20,
   parameter int DEN_W = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff;
   logic [NUM_W-1:0] quo_in;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] rem_in;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] count_ff;
   logic             active_ff;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             fits;

   // One restoring step: bring in the next dividend bit, subtract if it fits.
   // The dividend shifts out of the top of quo_ff while quotient bits enter
   // at the bottom.
   always_comb begin
      trial  = {rem_ff, quo_ff[NUM_W-1]};
      diff   = trial - {1'b0, den_ff};
      fits   = (trial >= {1'b0, den_ff});
      rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_in = {quo_ff[NUM_W-2:0], fits};
   end

   // Step counter: one quotient bit per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         count_ff  <= '0;
      end else if (start) begin
         active_ff <= 1'b1;
         count_ff  <= CNT_W'(NUM_W);
      end else if (active_ff) begin
         count_ff <= count_ff - 1'b1;
         if (count_ff == CNT_W'(1)) begin
            active_ff <= 1'b0;
         end
      end
   end

   // Shift registers of the dividend, remainder and quotient.
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= numer;
         rem_ff <= '0;
         den_ff <= denom;
      end else if (active_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done     = ~active_ff;
   assign quotient = quo_ff;

endmodule

/* rtl/core/ttcr_state.sv */
module ttcr_state (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  ttcr_pkg::ttcr_req_type   req_data,
   input  ttcr_pkg::ttcr_cfg_type   cfg,
   output ttcr_pkg::ttcr_status_type status
);

   import ttcr_pkg::*;

   logic [DEBOUNCE_W-1:0]   debounce_ff, debounce_in;
   logic [DELAY_W-1:0]      tap_timer_ff, tap_timer_in;
   logic [DELAY_W-1:0]      prev_interval_ff, prev_interval_in;
   logic                    tap_active_ff, tap_active_in;
   logic [DELAY_W-1:0]      delay_ff, delay_in;
   logic [ADC_BITS-1:0]     prev_knob_ff, prev_knob_in;
   logic [ADC_BITS-1:0]     depth_ff, depth_in;
   logic signed [LFO_W-1:0] lfo_ff, lfo_in;
   logic                    lfo_falling_ff, lfo_falling_in;
   logic                    edge_ff, edge_in;

   logic [DEBOUNCE_W-1:0]   shift_next;
   logic [DELAY_W:0]        interval_sum;
   logic [DELAY_W-1:0]      interval_avg;
   logic [KNOB_W-1:0]       adc_wide;
   logic [KNOB_W-1:0]       prev_wide;
   logic [KNOB_W-1:0]       hyst_wide;
   logic                    knob_moved;
   logic [DELAY_W-1:0]      knob_half;
   logic [DELAY_W-1:0]      knob_delay;
   logic signed [LFO_W-1:0] lfo_step;
   logic [LFO_W-1:0]        lfo_abs;

   // Helper values shared by the event cases.
   always_comb begin
      shift_next   = {debounce_ff[DEBOUNCE_W-2:0], ~req_data.button_level} | DEBOUNCE_MASK;
      interval_sum = {1'b0, tap_timer_ff} + {1'b0, prev_interval_ff};
      interval_avg = interval_sum[DELAY_W:1];

      // Knob hysteresis is compared one bit wider so that nothing wraps.
      adc_wide   = KNOB_W'(req_data.adc_value);
      prev_wide  = KNOB_W'(prev_knob_ff);
      hyst_wide  = KNOB_W'(cfg.knob_hysteresis);
      knob_moved = (adc_wide >= prev_wide + hyst_wide) ||
                   (adc_wide + hyst_wide <= prev_wide);

      // Delay from the knob floors at zero.
      knob_half  = DELAY_W'(req_data.adc_value >> 1);
      knob_delay = (cfg.knob_offset < knob_half) ? '0 : cfg.knob_offset - knob_half;

      lfo_step = lfo_falling_ff ? lfo_ff - 8'sd1 : lfo_ff + 8'sd1;
   end

   // Next state for one transaction.
   always_comb begin
      debounce_in      = debounce_ff;
      tap_timer_in     = tap_timer_ff;
      prev_interval_in = prev_interval_ff;
      tap_active_in    = tap_active_ff;
      delay_in         = delay_ff;
      prev_knob_in     = prev_knob_ff;
      depth_in         = depth_ff;
      lfo_in           = lfo_ff;
      lfo_falling_in   = lfo_falling_ff;
      edge_in          = 1'b0;

      case (req_data.action)
         ACT_TICK: begin
            // The tap timer saturates rather than wrapping.
            if (tap_timer_ff != '1) begin
               tap_timer_in = tap_timer_ff + 1'b1;
            end
         end
         ACT_BUTTON: begin
            debounce_in = shift_next;
            if (shift_next == DEBOUNCE_EDGE) begin
               edge_in = 1'b1;
               if (!tap_active_ff) begin
                  tap_timer_in     = '0;
                  prev_interval_in = '0;
                  tap_active_in    = 1'b1;
               end else if (interval_avg > cfg.tap_limit) begin
                  tap_active_in = 1'b0;
               end else begin
                  prev_interval_in = tap_timer_ff;
                  tap_timer_in     = '0;
                  delay_in         = interval_avg;
               end
            end
         end
         ACT_DELAY_KNOB: begin
            if (!tap_active_ff) begin
               delay_in = knob_delay;
            end else if (knob_moved) begin
               tap_active_in = 1'b0;
               delay_in      = knob_delay;
            end
            prev_knob_in = req_data.adc_value;
         end
         ACT_CHORUS_KNOB: begin
            depth_in = req_data.adc_value;
         end
         ACT_LFO_TICK: begin
            lfo_in = lfo_step;
            if (lfo_step >= LFO_PEAK) begin
               lfo_falling_in = 1'b1;
            end else if (lfo_step <= LFO_TROUGH) begin
               lfo_falling_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // State registers change only when a transaction is accepted.
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff      <= '0;
         tap_timer_ff     <= '0;
         prev_interval_ff <= '0;
         tap_active_ff    <= 1'b0;
         delay_ff         <= '0;
         prev_knob_ff     <= '0;
         depth_ff         <= '0;
         lfo_ff           <= '0;
         lfo_falling_ff   <= 1'b0;
         edge_ff          <= 1'b0;
      end else if (accept) begin
         debounce_ff      <= debounce_in;
         tap_timer_ff     <= tap_timer_in;
         prev_interval_ff <= prev_interval_in;
         tap_active_ff    <= tap_active_in;
         delay_ff         <= delay_in;
         prev_knob_ff     <= prev_knob_in;
         depth_ff         <= depth_in;
         lfo_ff           <= lfo_in;
         lfo_falling_ff   <= lfo_falling_in;
         edge_ff          <= edge_in;
      end
   end

   // The LFO leaves as sign and magnitude for the unsigned chorus product.
   assign lfo_abs = lfo_ff[LFO_W-1] ? LFO_W'(-lfo_ff) : LFO_W'(lfo_ff);

   assign status.delay_value   = delay_ff;
   assign status.tap_active    = tap_active_ff;
   assign status.edge_seen     = edge_ff;
   assign status.lfo_negative  = lfo_ff[LFO_W-1];
   assign status.lfo_magnitude = lfo_abs[LFO_MAG_W-1:0];
   assign status.chorus_depth  = depth_ff;

endmodule

/* rtl/core/tap_tempo_clock_rate_controller.sv */
// Channel   Handshake             Payload
// req       req_valid/req_ready   req_data: action, button_level, adc_value
// rsp       rsp_valid/rsp_ready   rsp_data: phase_step, delay_value, in_tap_mode, edge_seen
// csr       csr_write_en          csr_index, csr_write_data (write only, no wait)
//
// Each transaction runs from acceptance through S_LOAD, S_DIV, S_SUM and S_OUT
// to a loaded result; the next one is accepted only once the block is back in
// S_IDLE. The divide step is set by the bit-serial divider that forms
// rate_numerator / delay, one quotient bit per cycle; the chorus term is
// divided by 100 in a second serial divider running alongside.
// Reset is synchronous; it clears the event state and loads the register
// defaults. A stalled result holds in the output register, and the block
// takes the next transaction while it waits.
module tap_tempo_clock_rate_controller (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  ttcr_pkg::ttcr_req_type             req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output ttcr_pkg::ttcr_rsp_type             rsp_data,
   input  logic                               csr_write_en,
   input  logic [ttcr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ttcr_pkg::CFG_W-1:0]         csr_write_data
);

   import ttcr_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LOAD = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_SUM  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   ttcr_cfg_type    cfg_ff;
   ttcr_status_type status;
   logic [2:0]      state_ff, state_in;
   logic            accept;
   logic            div_start;
   logic            rate_done;
   logic            chorus_done;
   logic [CFG_W-1:0]  rate_quo;
   logic [PROD_W-1:0] chorus_prod;
   logic [PROD_W-1:0] chorus_quo;
   logic [CFG_W-1:0]  base_inc;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic signed [SUM_W-1:0] min_wide;
   logic signed [SUM_W-1:0] max_wide;
   logic [CFG_W-1:0]  clamped;
   logic            out_free;
   logic            rsp_valid_ff;
   ttcr_rsp_type    rsp_data_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_RATE_NUMERATOR:  cfg_ff.rate_numerator  <= csr_write_data;
            CSR_INCREMENT_MIN:   cfg_ff.increment_min   <= csr_write_data;
            CSR_INCREMENT_MAX:   cfg_ff.increment_max   <= csr_write_data;
            CSR_TAP_LIMIT:       cfg_ff.tap_limit       <= csr_write_data[DELAY_W-1:0];
            CSR_KNOB_OFFSET:     cfg_ff.knob_offset     <= csr_write_data[DELAY_W-1:0];
            CSR_KNOB_HYSTERESIS: cfg_ff.knob_hysteresis <= csr_write_data[HYST_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid & req_ready;
   assign div_start = (state_ff == S_LOAD);
   assign out_free  = ~rsp_valid_ff | rsp_ready;

   // Event state: debounce, tap timing, knobs and LFO.
   ttcr_state u_state (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .status   (status)
   );

   // Rate quotient: numerator over the delay time.
   ttcr_div #(
      .NUM_W (CFG_W),
      .DEN_W (DELAY_W)
   ) u_rate_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (cfg_ff.rate_numerator),
      .denom    (status.delay_value),
      .done     (rate_done),
      .quotient (rate_quo)
   );

   // Chorus term: |lfo| * depth / 100, sign restored afterwards.
   assign chorus_prod = PROD_W'(status.lfo_magnitude) * PROD_W'(status.chorus_depth);

   ttcr_div #(
      .NUM_W (PROD_W),
      .DEN_W (LFO_MAG_W)
   ) u_chorus_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (chorus_prod),
      .denom    (LFO_SCALE),
      .done     (chorus_done),
      .quotient (chorus_quo)
   );

   // Signed sum of the base increment and the chorus term; zero delay uses the maximum.
   always_comb begin
      base_inc = (status.delay_value == '0) ? cfg_ff.increment_max : rate_quo;
      if (status.lfo_negative) begin
         sum_in = SUM_W'(base_inc) - SUM_W'(chorus_quo);
      end else begin
         sum_in = SUM_W'(base_inc) + SUM_W'(chorus_quo);
      end
   end

   // Clamp: raise to the minimum first, then the maximum wins.
   always_comb begin
      min_wide = SUM_W'(cfg_ff.increment_min);
      max_wide = SUM_W'(cfg_ff.increment_max);
      if (sum_ff > max_wide) begin
         clamped = cfg_ff.increment_max;
      end else if (sum_ff < min_wide) begin
         clamped = (min_wide > max_wide) ? cfg_ff.increment_max : cfg_ff.increment_min;
      end else begin
         clamped = sum_ff[CFG_W-1:0];
      end
   end

   // Sequencer for one transaction.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: state_in = S_DIV;
         S_DIV: begin
            if (rate_done && chorus_done) begin
               state_in = S_SUM;
            end
         end
         S_SUM: state_in = S_OUT;
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_SUM) begin
         sum_ff <= sum_in;
      end
   end

   // Output register parts the result channel from the datapath.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_OUT && out_free) begin
         rsp_data_ff.phase_step  <= NCO_BITS'(clamped);
         rsp_data_ff.delay_value <= status.delay_value;
         rsp_data_ff.in_tap_mode <= status.tap_active;
         rsp_data_ff.edge_seen   <= status.edge_seen;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
   import ttcr_pkg::*;

   localparam int CLOCK_HALF   = 2;
   localparam int RESET_CYCLES = 9;
   localparam int CYCLE_LIMIT  = 250000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 60;
   localparam int MAX_GAP      = 8;
   localparam int ADC_MAX      = (1 << ADC_BITS) - 1;
   localparam int NCO_MAX      = (1 << NCO_BITS) - 1;
   localparam int DELAY_MAX    = (1 << DELAY_W) - 1;
   localparam int HYST_MAX     = (1 << HYST_W) - 1;

   // Action codes that the block must ignore.
   localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

   // Raw button levels; the pin is active low.
   localparam logic BTN_UP   = 1'b1;
   localparam logic BTN_DOWN = 1'b0;

   // Tracks the controller state and queues the increment reports it owes.
   class increment_tracker;
      ttcr_cfg_type regs;
      logic [DEBOUNCE_W-1:0] debounce;
      logic [DELAY_W-1:0]    tap_timer;
      logic [DELAY_W-1:0]    prev_interval;
      logic [DELAY_W-1:0]    delay;
      logic [ADC_BITS-1:0]   prev_knob;
      logic [ADC_BITS-1:0]   chorus;
      logic                  tap_active;
      logic                  lfo_falling;
      int                    lfo_level;
      ttcr_rsp_type          increments_due[$];
      int                    errors;
      int                    checked;
      int                    press_edges;
      int                    lfo_turns;

      function new();
         regs          = CFG_RESET;
         debounce      = '0;
         tap_timer     = '0;
         prev_interval = '0;
         delay         = '0;
         prev_knob     = '0;
         chorus        = '0;
         tap_active    = 1'b0;
         lfo_falling   = 1'b0;
         lfo_level     = 0;
         errors        = 0;
         checked       = 0;
         press_edges   = 0;
         lfo_turns     = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [CFG_W-1:0] value);
         case (index)
            CSR_RATE_NUMERATOR:  regs.rate_numerator  = value;
            CSR_INCREMENT_MIN:   regs.increment_min   = value;
            CSR_INCREMENT_MAX:   regs.increment_max   = value;
            CSR_TAP_LIMIT:       regs.tap_limit       = value[DELAY_W-1:0];
            CSR_KNOB_OFFSET:     regs.knob_offset     = value[DELAY_W-1:0];
            CSR_KNOB_HYSTERESIS: regs.knob_hysteresis = value[HYST_W-1:0];
            default: ;
         endcase
      endfunction

      // Delay from the knob: offset minus half the reading, floored at zero.
      function logic [DELAY_W-1:0] knob_delay(logic [ADC_BITS-1:0] reading);
         int half;
         half = int'(reading) >> 1;
         if (int'(regs.knob_offset) < half) return '0;
         return DELAY_W'(int'(regs.knob_offset) - half);
      endfunction

      // Apply one accepted event to the state and queue the report it causes.
      function void accept_event(ttcr_req_type item);
         logic         pressed;
         logic         press_edge;
         int           avg;
         int           hyst;
         int           chorus_term;
         longint       quot;
         longint       total;
         ttcr_rsp_type report;
         pressed    = ~item.button_level;
         press_edge = 1'b0;
         hyst       = int'(regs.knob_hysteresis);
         case (item.action)
            ACT_TICK: begin
               if (tap_timer != DELAY_W'(DELAY_MAX)) tap_timer++;
            end
            ACT_BUTTON: begin
               debounce = (debounce << 1) | DEBOUNCE_W'(pressed) | DEBOUNCE_MASK;
               if (debounce == DEBOUNCE_EDGE) begin
                  press_edge = 1'b1;
                  press_edges++;
                  if (!tap_active) begin
                     tap_timer     = '0;
                     prev_interval = '0;
                     tap_active    = 1'b1;
                  end else begin
                     avg = (int'(tap_timer) + int'(prev_interval)) >> 1;
                     if (avg > int'(regs.tap_limit)) begin
                        tap_active = 1'b0;
                     end else begin
                        prev_interval = tap_timer;
                        tap_timer     = '0;
                        delay         = DELAY_W'(avg);
                     end
                  end
               end
            end
            ACT_DELAY_KNOB: begin
               // In tap mode only a move of at least the hysteresis takes over.
               if (tap_active) begin
                  if (int'(item.adc_value) >= int'(prev_knob) + hyst ||
                      int'(item.adc_value) + hyst <= int'(prev_knob)) begin
                     tap_active = 1'b0;
                     delay      = knob_delay(item.adc_value);
                  end
               end else begin
                  delay = knob_delay(item.adc_value);
               end
               prev_knob = item.adc_value;
            end
            ACT_CHORUS_KNOB: begin
               chorus = item.adc_value;
            end
            ACT_LFO_TICK: begin
               lfo_level += lfo_falling ? -1 : 1;
               if (lfo_level >= int'(LFO_PEAK)) begin
                  if (!lfo_falling) lfo_turns++;
                  lfo_falling = 1'b1;
               end else if (lfo_level <= int'(LFO_TROUGH)) begin
                  if (lfo_falling) lfo_turns++;
                  lfo_falling = 1'b0;
               end
            end
            default: ;
         endcase

         // Quotient plus the signed chorus term, then the two clamps in order.
         if (delay == '0) quot = longint'(regs.increment_max);
         else quot = longint'(regs.rate_numerator) / longint'(delay);
         chorus_term = (lfo_level * int'(chorus)) / int'(LFO_SCALE);
         total = quot + longint'(chorus_term);
         if (total < longint'(regs.increment_min)) total = longint'(regs.increment_min);
         if (total > longint'(regs.increment_max)) total = longint'(regs.increment_max);

         report.phase_step  = NCO_BITS'(total);
         report.delay_value = delay;
         report.in_tap_mode = tap_active;
         report.edge_seen   = press_edge;
         increments_due.push_back(report);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      // Compare one accepted result with the oldest outstanding report.
      function void check_result(ttcr_rsp_type got);
         ttcr_rsp_type want;
         checked++;
         if (increments_due.size() == 0) begin
            $display("%0t ns: result with no transaction outstanding, actual %h", $time, got);
            errors++;
            return;
         end
         want = increments_due.pop_front();
         compare_field("phase_step", 32'(want.phase_step), 32'(got.phase_step));
         compare_field("delay_value", 32'(want.delay_value), 32'(got.delay_value));
         compare_field("in_tap_mode", 32'(want.in_tap_mode), 32'(got.in_tap_mode));
         compare_field("edge_seen", 32'(want.edge_seen), 32'(got.edge_seen));
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   ttcr_req_type           req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   ttcr_rsp_type           rsp_data;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CFG_W-1:0]       csr_write_data;

   increment_tracker tracker = new();
   int   cycle_count = 0;
   int   items_sent  = 0;
   int   settings    = 0;
   logic no_idle     = 1'b0;
   logic hold_request = 1'b0;

   tap_tempo_clock_rate_controller u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   initial clock = 1'b0;
   always #(CLOCK_HALF) clock = ~clock;

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Offer one event after a random gap and hold it until the block takes it.
   task automatic send_item(input logic [ACTION_W-1:0] act, input logic level,
                            input logic [ADC_BITS-1:0] adc);
      int           gap;
      ttcr_req_type item;
      item.action       = act;
      item.button_level = level;
      item.adc_value    = adc;
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_ready !== 1'b1);
      tracker.accept_event(item);
      if (act < ACT_SPARE_LO) items_sent++;
   endtask

   // A clean press: two released samples, then two pressed ones.
   task automatic send_press();
      send_item(ACT_BUTTON, BTN_UP, ADC_BITS'($urandom));
      send_item(ACT_BUTTON, BTN_UP, ADC_BITS'($urandom));
      send_item(ACT_BUTTON, BTN_DOWN, ADC_BITS'($urandom));
      send_item(ACT_BUTTON, BTN_DOWN, ADC_BITS'($urandom));
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= index;
      csr_write_data <= value;
      tracker.write_reg(index, value);
      @(negedge clock);
      csr_write_en   <= 1'b0;
   endtask

   task automatic load_config(input int numerator, input int inc_min, input int inc_max,
                              input int limit, input int offset, input int hyst);
      write_reg(CSR_RATE_NUMERATOR, CFG_W'(numerator));
      write_reg(CSR_INCREMENT_MIN, CFG_W'(inc_min));
      write_reg(CSR_INCREMENT_MAX, CFG_W'(inc_max));
      write_reg(CSR_TAP_LIMIT, CFG_W'(limit));
      write_reg(CSR_KNOB_OFFSET, CFG_W'(offset));
      write_reg(CSR_KNOB_HYSTERESIS, CFG_W'(hyst));
      settings++;
   endtask

   // Stop offering and wait until every result has come back.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.increments_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Mostly tap trains, LFO sweeps and knob moves, with some noise mixed in.
   // Long bursts stop once the phase has sent its share of transactions.
   task automatic run_random(input int count);
      int stop_at;
      int kind;
      int taps;
      int ticks;
      int val;
      int span;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         kind = $urandom_range(0, 9);
         case (kind)
            0, 1, 2, 3: begin
               taps = $urandom_range(1, 4);
               repeat (taps) begin
                  if (items_sent < stop_at) begin
                     if ($urandom_range(0, 4) == 0) begin
                        repeat ($urandom_range(1, 3))
                           send_item(ACT_BUTTON, 1'($urandom), ADC_BITS'($urandom));
                     end
                     send_press();
                     ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 80)
                                                         : $urandom_range(0, 12);
                     repeat (ticks) begin
                        if (items_sent < stop_at)
                           send_item(ACT_TICK, 1'($urandom), ADC_BITS'($urandom));
                     end
                  end
               end
            end
            4, 5, 6: begin
               repeat ($urandom_range(20, 60)) begin
                  if (items_sent < stop_at)
                     send_item(ACT_LFO_TICK, 1'($urandom), ADC_BITS'($urandom));
               end
            end
            7: begin
               // Either a small move around the last reading or a jump anywhere.
               if ($urandom_range(0, 1) == 0) begin
                  span = int'(tracker.regs.knob_hysteresis);
                  val  = int'($urandom_range(0, 2 * span)) + int'(tracker.prev_knob) - span;
                  if (val < 0) val = 0;
                  if (val > ADC_MAX) val = ADC_MAX;
               end else begin
                  val = $urandom_range(0, ADC_MAX);
               end
               send_item(ACT_DELAY_KNOB, 1'($urandom), ADC_BITS'(val));
            end
            8: begin
               send_item(ACT_CHORUS_KNOB, 1'($urandom), ADC_BITS'($urandom));
            end
            default: begin
               repeat ($urandom_range(1, 6))
                  send_item(ACTION_W'($urandom), 1'($urandom), ADC_BITS'($urandom));
            end
         endcase
      end
   endtask

   task automatic random_config();
      int inc_min;
      inc_min = $urandom_range(0, 3000);
      load_config($urandom_range(1, NCO_MAX), inc_min, $urandom_range(inc_min, NCO_MAX),
                  $urandom_range(1, 60), $urandom_range(0, 1100), $urandom_range(1, 40));
   endtask

   // Result side: random stalls, plus one long hold-off when asked.
   initial begin : result_sink
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(negedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         tracker.check_result(rsp_data);
         @(negedge clock);
      end
   end

   // Main sequence: reset, directed events, then random phases per setting.
   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      csr_write_en   = 1'b0;
      csr_index      = '0;
      csr_write_data = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Reset defaults: zero delay at first, knob extremes, a tap pair and a
      // knob move exactly at the hysteresis, then an ignored action.
      send_item(ACT_LFO_TICK, BTN_UP, '0);
      send_item(ACT_DELAY_KNOB, BTN_DOWN, '0);
      send_item(ACT_DELAY_KNOB, BTN_UP, ADC_BITS'(ADC_MAX));
      send_item(ACT_CHORUS_KNOB, BTN_DOWN, ADC_BITS'(ADC_MAX));
      send_press();
      send_item(ACT_TICK, BTN_DOWN, ADC_BITS'(ADC_MAX));
      send_item(ACT_TICK, BTN_UP, '0);
      send_press();
      send_item(ACT_DELAY_KNOB, BTN_UP, ADC_BITS'(ADC_MAX));
      send_item(ACT_DELAY_KNOB, BTN_UP, ADC_BITS'(ADC_MAX - 5));
      send_item(ACT_SPARE_HI, BTN_DOWN, ADC_BITS'(ADC_MAX));
      drain();

      // Every register at its top value but the minimum increment, which is zero; the receiver holds off once here.
      load_config(NCO_MAX, 0, NCO_MAX, DELAY_MAX, DELAY_MAX, HYST_MAX);
      hold_request = 1'b1;
      run_random(90);
      drain();

      // Bottom values with crossed clamps; the knob would drive the delay below zero, so it floors at zero.
      load_config(1, NCO_MAX, 0, 1, 0, 1);
      send_item(ACT_DELAY_KNOB, BTN_UP, ADC_BITS'(ADC_MAX));
      send_item(ACT_LFO_TICK, BTN_DOWN, '0);
      run_random(80);
      drain();

      random_config();
      run_random(90);
      drain();

      random_config();
      no_idle = 1'b1;
      run_random(90);
      no_idle = 1'b0;
      drain();

      random_config();
      run_random(100);
      drain();

      $display("Ran %0d transactions under %0d register settings, %0d results checked.",
               items_sent, settings + 1, tracker.checked);
      $display("Saw %0d debounced press edges and %0d LFO turning points.",
               tracker.press_edges, tracker.lfo_turns);
      if (tracker.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
